### hdl/document_topic_posterior_assert.svh
// assertion macros shared by the checker of the document topic posterior block
// needs clk and rst_n in the scope where a macro is used
`ifndef DOCUMENT_TOPIC_POSTERIOR_ASSERT_SVH
`define DOCUMENT_TOPIC_POSTERIOR_ASSERT_SVH

// same-cycle implication
`define DTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dtp_pkg.sv
// shared types, codes and constants of the document topic posterior block
// no dependencies
`timescale 1ns / 1ps

package dtp_pkg;

    localparam int MAX_TOPICS_DEF    = 16;
    localparam int VOCAB_SIZE_DEF    = 4096;
    localparam int LOG_FRAC_BITS_DEF = 10;

    // item kinds
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_PRIOR = 2'd1;
    localparam logic [1:0] KIND_FEAT  = 2'd2;

    // quotient bits below the integer bit of the normalizing divide
    localparam int DIV_STEPS = 16;
    // taylor terms and squarings of the exponential
    localparam int EXP_TERMS     = 16;
    localparam int EXP_SQUARINGS = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEAT_RD,
        ST_FEAT_MUL,
        ST_FEAT_WR,
        ST_MAX_RD,
        ST_MAX_CMP,
        ST_EXP_RD,
        ST_EXP_GO,
        ST_EXP_WAIT,
        ST_DIV_RD,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_OUT
    } dtp_state_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_MUL,
        EX_RECIP,
        EX_CORR,
        EX_VSUB,
        EX_SQ,
        EX_SQR,
        EX_FIN
    } dtp_exp_state_t;

    typedef struct packed {
        logic load_word;
        logic load_prior;
        logic feat_take;
        logic rd;
        logic mul;
        logic use_prior;
        logic score_we;
        logic max_upd;
        logic max_first;
        logic sum_clr;
        logic exp_start;
        logic e_we;
        logic e_rd;
        logic div_init;
        logic div_step;
        logic out_load;
        logic last;
    } dtp_cmd_t;

    typedef struct packed {
        logic exp_done;
    } dtp_status_t;

    // floor(2^32 / k) for the taylor divisors, k of one is passed through
    function automatic logic [31:0] dtp_recip(input logic [4:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                5'd2:    r = 32'd2147483648;
                5'd3:    r = 32'd1431655765;
                5'd4:    r = 32'd1073741824;
                5'd5:    r = 32'd858993459;
                5'd6:    r = 32'd715827882;
                5'd7:    r = 32'd613566756;
                5'd8:    r = 32'd536870912;
                5'd9:    r = 32'd477218588;
                5'd10:   r = 32'd429496729;
                5'd11:   r = 32'd390451572;
                5'd12:   r = 32'd357913941;
                5'd13:   r = 32'd330382099;
                5'd14:   r = 32'd306783378;
                5'd15:   r = 32'd286331153;
                5'd16:   r = 32'd268435456;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/document_topic_posterior.sv
// top level of the document topic posterior block: controller plus datapath
// depends on dtp_pkg, dtp_ctrl, dtp_datapath
`timescale 1ns / 1ps

// usage
// - item channel (item_valid / item_stall): kind 0 loads one log P(word|topic) entry,
//   kind 1 loads one log prior, kind 2 carries one (word, count) feature of a document
// - a load transfer never stalls the item channel; kind 3 is dropped
// - a feature transfer sweeps all MAX_TOPICS scores through the score memory,
//   reading, scaling and writing back each topic, and the item channel stalls meanwhile
// - the first feature of a document seeds each score from its prior
// - on a feature with doc_end the block runs a max sweep over the topics in use,
//   then the exponential unit per topic in use (bound by its taylor loop and shared
//   multiplier), then a restoring divide per result
// - result channel (result_valid / result_stall): one transfer per topic in use,
//   last_topic high on the final one; the item channel stays stalled until then
// - while the receiver stalls, the result payload holds and the block waits
// - cfg_wr_en / cfg_wr_data write the topic count; zero acts as one, larger than
//   MAX_TOPICS acts as MAX_TOPICS; write it only while the block is idle
// - reset clears the controller, the open-document flag and sets the topic count
//   to one; the tables hold nothing defined until loaded

module document_topic_posterior #(
    parameter int MAX_TOPICS    = dtp_pkg::MAX_TOPICS_DEF,
    parameter int VOCAB_SIZE    = dtp_pkg::VOCAB_SIZE_DEF,
    parameter int LOG_FRAC_BITS = dtp_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         kind,
    input  logic [11:0]        word_index,
    input  logic [3:0]         topic_index,
    input  logic signed [15:0] log_value,
    input  logic [15:0]        word_count,
    input  logic               doc_end,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [3:0]         topic_out,
    output logic [16:0]        posterior,
    output logic               last_topic,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data
);

    localparam int TW = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;

    dtp_pkg::dtp_cmd_t    cmd;
    dtp_pkg::dtp_status_t status;
    logic [TW-1:0]        topic_sel;

    // sequencing of loads, feature sweeps, softmax and result transfers
    dtp_ctrl #(.MAX_TOPICS(MAX_TOPICS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .kind         (kind),
        .doc_end      (doc_end),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_stall (result_stall),
        .status       (status),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd),
        .topic_sel    (topic_sel)
    );

    // tables, scores, exponential unit and divider
    dtp_datapath #(
        .MAX_TOPICS    (MAX_TOPICS),
        .VOCAB_SIZE    (VOCAB_SIZE),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_index  (word_index),
        .topic_index (topic_index),
        .log_value   (log_value),
        .word_count  (word_count),
        .cmd         (cmd),
        .topic_sel   (topic_sel),
        .status      (status),
        .topic_out   (topic_out),
        .posterior   (posterior),
        .last_topic  (last_topic)
    );

endmodule

### hdl/dtp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dtp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/dtp_exp.sv
// iterative exp(-diff) unit: taylor series on diff/16, then four squarings
// depends on dtp_pkg
`timescale 1ns / 1ps

module dtp_exp #(
    parameter int LOG_FRAC_BITS = dtp_pkg::LOG_FRAC_BITS_DEF,
    localparam int DW = LOG_FRAC_BITS + 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          zero,
    input  logic [DW-1:0] diff,
    output logic          done,
    output logic [16:0]   e
);

    dtp_pkg::dtp_exp_state_t st_reg, st_next;
    logic [4:0]  k_reg, k_next;
    logic [1:0]  sq_reg, sq_next;
    logic [31:0] term_reg, term_next;
    logic [30:0] y_reg, y_next;
    logic [33:0] pos_reg, pos_next;
    logic [33:0] neg_reg, neg_next;
    logic [31:0] t_reg, t_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] v_reg, v_next;
    logic [16:0] e_reg, e_next;
    logic        done_reg, done_next;

    logic [31:0] t_w;
    logic [31:0] q0;
    logic [36:0] rem_w;
    logic [31:0] q_w;

    // truncated product, then reciprocal quotient with one correction step
    assign t_w   = prod_reg[62:31];
    assign q0    = prod_reg[63:32];
    assign rem_w = 37'(t_reg) - 37'(q0) * 37'(k_reg);
    assign q_w   = (k_reg == 5'd1) ? t_reg : q0 + 32'(rem_w >= 37'(k_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= dtp_pkg::EX_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        sq_reg   <= sq_next;
        term_reg <= term_next;
        y_reg    <= y_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        t_reg    <= t_next;
        prod_reg <= prod_next;
        v_reg    <= v_next;
        e_reg    <= e_next;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            dtp_pkg::EX_IDLE:  if (start && !zero) st_next = dtp_pkg::EX_MUL;
            dtp_pkg::EX_MUL:   st_next = dtp_pkg::EX_RECIP;
            dtp_pkg::EX_RECIP: st_next = dtp_pkg::EX_CORR;
            dtp_pkg::EX_CORR:
                st_next = (k_reg == 5'(dtp_pkg::EXP_TERMS)) ? dtp_pkg::EX_VSUB
                                                            : dtp_pkg::EX_MUL;
            dtp_pkg::EX_VSUB:  st_next = dtp_pkg::EX_SQ;
            dtp_pkg::EX_SQ:    st_next = dtp_pkg::EX_SQR;
            dtp_pkg::EX_SQR:
                st_next = (sq_reg == 2'(dtp_pkg::EXP_SQUARINGS - 1)) ? dtp_pkg::EX_FIN
                                                                     : dtp_pkg::EX_SQ;
            dtp_pkg::EX_FIN:   st_next = dtp_pkg::EX_IDLE;
            default:           st_next = dtp_pkg::EX_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        k_next    = k_reg;
        sq_next   = sq_reg;
        term_next = term_reg;
        y_next    = y_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        t_next    = t_reg;
        prod_next = prod_reg;
        v_next    = v_reg;
        e_next    = e_reg;
        done_next = 1'b0;
        unique case (st_reg)
            dtp_pkg::EX_IDLE:
            begin
                if (start)
                begin
                    if (zero)
                    begin
                        e_next    = 17'd0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        y_next    = {diff, {(27 - LOG_FRAC_BITS){1'b0}}};
                        term_next = 32'h8000_0000;
                        pos_next  = 34'h0_8000_0000;
                        neg_next  = 34'd0;
                        k_next    = 5'd1;
                    end
                end
            end
            dtp_pkg::EX_MUL:
                prod_next = 64'(term_reg) * 64'(y_reg);
            dtp_pkg::EX_RECIP:
            begin
                t_next    = t_w;
                prod_next = 64'(t_w) * 64'(dtp_pkg::dtp_recip(k_reg));
            end
            dtp_pkg::EX_CORR:
            begin
                term_next = q_w;
                if (k_reg[0])
                begin
                    neg_next = neg_reg + 34'(q_w);
                end
                else
                begin
                    pos_next = pos_reg + 34'(q_w);
                end
                k_next = k_reg + 5'd1;
            end
            dtp_pkg::EX_VSUB:
            begin
                v_next  = 32'(pos_reg - neg_reg);
                sq_next = 2'd0;
            end
            dtp_pkg::EX_SQ:
                prod_next = 64'(v_reg) * 64'(v_reg);
            dtp_pkg::EX_SQR:
            begin
                v_next  = 32'((prod_reg + 64'h4000_0000) >> 31);
                sq_next = sq_reg + 2'd1;
            end
            dtp_pkg::EX_FIN:
            begin
                e_next    = 17'((33'(v_reg) + 33'h4000) >> 15);
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign done = done_reg;
    assign e    = e_reg;

endmodule

### hdl/dtp_datapath.sv
// tables, topic scores, max search, exponentials and normalizing divide
// depends on dtp_pkg, dtp_ram, dtp_exp
`timescale 1ns / 1ps

module dtp_datapath #(
    parameter int MAX_TOPICS    = dtp_pkg::MAX_TOPICS_DEF,
    parameter int VOCAB_SIZE    = dtp_pkg::VOCAB_SIZE_DEF,
    parameter int LOG_FRAC_BITS = dtp_pkg::LOG_FRAC_BITS_DEF,
    localparam int TW = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [11:0]           word_index,
    input  logic [3:0]            topic_index,
    input  logic signed [15:0]    log_value,
    input  logic [15:0]           word_count,
    input  dtp_pkg::dtp_cmd_t     cmd,
    input  logic [TW-1:0]         topic_sel,
    output dtp_pkg::dtp_status_t  status,
    output logic [3:0]            topic_out,
    output logic [16:0]           posterior,
    output logic                  last_topic
);

    localparam int WDEPTH = VOCAB_SIZE * MAX_TOPICS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int SUM_W  = 17 + TW;
    localparam int DW     = LOG_FRAC_BITS + 4;
    localparam logic [47:0] EXP_LIMIT = 48'(16) << LOG_FRAC_BITS;
    localparam logic signed [47:0] SCORE_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SCORE_MIN = {1'b1, {47{1'b0}}};

    logic [11:0]          word_reg;
    logic [15:0]          count_reg;
    logic                 word_ok_reg;
    logic signed [32:0]   prod_reg;
    logic signed [47:0]   base_reg;
    logic signed [47:0]   mx_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [16:0]          q_reg, q_next;
    logic [3:0]           topic_out_reg;
    logic [16:0]          posterior_reg;
    logic                 last_reg;

    logic                 word_ok_in;
    logic                 topic_ok_in;
    logic [WAW-1:0]       w_waddr, w_raddr;
    logic [15:0]          w_rdata, p_rdata;
    logic [47:0]          s_rdata;
    logic [16:0]          e_rdata;
    logic signed [15:0]   w_s, p_s;
    logic signed [47:0]   score_s;
    logic signed [48:0]   acc_w;
    logic signed [47:0]   score_wdata;
    logic [47:0]          diff_w;
    logic                 exp_zero;
    logic                 exp_done;
    logic [16:0]          exp_e;
    logic                 ge_init;
    logic [SUM_W:0]       rem_shift;

    assign word_ok_in  = 32'(word_index) < 32'(VOCAB_SIZE);
    assign topic_ok_in = 32'(topic_index) < 32'(MAX_TOPICS);
    assign w_waddr = WAW'(word_index) * WAW'(MAX_TOPICS) + WAW'(topic_index);
    assign w_raddr = WAW'(word_reg) * WAW'(MAX_TOPICS) + WAW'(topic_sel);

    dtp_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_word_ram (
        .clk   (clk),
        .we    (cmd.load_word && word_ok_in && topic_ok_in),
        .waddr (w_waddr),
        .wdata (log_value),
        .re    (cmd.rd),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dtp_ram #(.WIDTH(16), .DEPTH(MAX_TOPICS)) u_prior_ram (
        .clk   (clk),
        .we    (cmd.load_prior && topic_ok_in),
        .waddr (TW'(topic_index)),
        .wdata (log_value),
        .re    (cmd.rd),
        .raddr (topic_sel),
        .rdata (p_rdata)
    );

    dtp_ram #(.WIDTH(48), .DEPTH(MAX_TOPICS)) u_score_ram (
        .clk   (clk),
        .we    (cmd.score_we),
        .waddr (topic_sel),
        .wdata (score_wdata),
        .re    (cmd.rd),
        .raddr (topic_sel),
        .rdata (s_rdata)
    );

    dtp_ram #(.WIDTH(17), .DEPTH(MAX_TOPICS)) u_e_ram (
        .clk   (clk),
        .we    (cmd.e_we),
        .waddr (topic_sel),
        .wdata (exp_e),
        .re    (cmd.e_rd),
        .raddr (topic_sel),
        .rdata (e_rdata)
    );

    assign w_s     = w_rdata;
    assign p_s     = p_rdata;
    assign score_s = s_rdata;

    // score update with saturation to 48 bits
    assign acc_w = {base_reg[47], base_reg} + {{16{prod_reg[32]}}, prod_reg};
    always_comb
    begin
        if (acc_w[48] != acc_w[47])
        begin
            score_wdata = acc_w[48] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            score_wdata = acc_w[47:0];
        end
    end

    // distance below the maximum
    assign diff_w   = mx_reg - score_s;
    assign exp_zero = diff_w >= EXP_LIMIT;

    dtp_exp #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.exp_start),
        .zero  (exp_zero),
        .diff  (diff_w[DW-1:0]),
        .done  (exp_done),
        .e     (exp_e)
    );

    assign status.exp_done = exp_done;

    // restoring divide of e * 2^16 by the sum, one quotient bit a cycle
    assign ge_init   = SUM_W'(e_rdata) >= sum_reg;
    assign rem_shift = {rem_reg, 1'b0};
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (cmd.div_init)
        begin
            q_next   = {16'd0, ge_init};
            rem_next = ge_init ? SUM_W'(e_rdata) - sum_reg : SUM_W'(e_rdata);
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= (SUM_W + 1)'(sum_reg))
            begin
                rem_next = SUM_W'(rem_shift - (SUM_W + 1)'(sum_reg));
                q_next   = {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[SUM_W-1:0];
                q_next   = {q_reg[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.feat_take)
        begin
            word_reg    <= word_index;
            count_reg   <= word_count;
            word_ok_reg <= word_ok_in;
        end
        if (cmd.mul)
        begin
            prod_reg <= word_ok_reg ? signed'({1'b0, count_reg}) * w_s : 33'sd0;
            base_reg <= cmd.use_prior ? {{32{p_s[15]}}, p_s} : score_s;
        end
        if (cmd.max_upd && (cmd.max_first || score_s > mx_reg))
        begin
            mx_reg <= score_s;
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.e_we)
        begin
            sum_reg <= sum_reg + SUM_W'(exp_e);
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (cmd.out_load)
        begin
            posterior_reg <= (sum_reg == '0) ? 17'd0 : q_next;
            topic_out_reg <= 4'(topic_sel);
            last_reg      <= cmd.last;
        end
    end

    assign topic_out  = topic_out_reg;
    assign posterior  = posterior_reg;
    assign last_topic = last_reg;

endmodule

### hdl/dtp_ctrl.sv
// controller state machine: item intake, topic sweeps and result handshake
// depends on dtp_pkg
`timescale 1ns / 1ps

module dtp_ctrl #(
    parameter int MAX_TOPICS = dtp_pkg::MAX_TOPICS_DEF,
    localparam int TW = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1,
    localparam int NW = $clog2(MAX_TOPICS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           kind,
    input  logic                 doc_end,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  logic                 result_stall,
    input  dtp_pkg::dtp_status_t status,
    output logic                 item_stall,
    output logic                 result_valid,
    output dtp_pkg::dtp_cmd_t    cmd,
    output logic [TW-1:0]        topic_sel
);

    dtp_pkg::dtp_state_t state_reg, state_next;
    logic [TW-1:0] z_reg, z_next;
    logic [3:0]    step_reg, step_next;
    logic          doc_open_reg, doc_open_next;
    logic          end_reg, end_next;
    logic [NW-1:0] active_reg, active_next;

    logic accept;
    logic z_last_all;
    logic z_last_act;

    assign accept     = item_valid && (state_reg == dtp_pkg::ST_IDLE);
    assign z_last_all = z_reg == TW'(MAX_TOPICS - 1);
    assign z_last_act = NW'(z_reg) == (active_reg - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dtp_pkg::ST_IDLE;
            z_reg        <= '0;
            step_reg     <= '0;
            doc_open_reg <= 1'b0;
            end_reg      <= 1'b0;
            active_reg   <= NW'(1);
        end
        else
        begin
            state_reg    <= state_next;
            z_reg        <= z_next;
            step_reg     <= step_next;
            doc_open_reg <= doc_open_next;
            end_reg      <= end_next;
            active_reg   <= active_next;
        end
    end

    // topic count register, clamped to the supported range
    always_comb
    begin
        active_next = active_reg;
        if (cfg_wr_en)
        begin
            priority if (cfg_wr_data == 5'd0)
            begin
                active_next = NW'(1);
            end
            else if (32'(cfg_wr_data) > 32'(MAX_TOPICS))
            begin
                active_next = NW'(MAX_TOPICS);
            end
            else
            begin
                active_next = NW'(cfg_wr_data);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        z_next        = z_reg;
        step_next     = step_reg;
        doc_open_next = doc_open_reg;
        end_next      = end_reg;
        unique case (state_reg)
            dtp_pkg::ST_IDLE:
            begin
                if (accept && kind == dtp_pkg::KIND_FEAT)
                begin
                    end_next   = doc_end;
                    z_next     = '0;
                    state_next = dtp_pkg::ST_FEAT_RD;
                end
            end
            dtp_pkg::ST_FEAT_RD:  state_next = dtp_pkg::ST_FEAT_MUL;
            dtp_pkg::ST_FEAT_MUL: state_next = dtp_pkg::ST_FEAT_WR;
            dtp_pkg::ST_FEAT_WR:
            begin
                if (z_last_all)
                begin
                    z_next        = '0;
                    doc_open_next = !end_reg;
                    state_next    = end_reg ? dtp_pkg::ST_MAX_RD : dtp_pkg::ST_IDLE;
                end
                else
                begin
                    z_next     = z_reg + TW'(1);
                    state_next = dtp_pkg::ST_FEAT_RD;
                end
            end
            dtp_pkg::ST_MAX_RD:   state_next = dtp_pkg::ST_MAX_CMP;
            dtp_pkg::ST_MAX_CMP:
            begin
                if (z_last_act)
                begin
                    z_next     = '0;
                    state_next = dtp_pkg::ST_EXP_RD;
                end
                else
                begin
                    z_next     = z_reg + TW'(1);
                    state_next = dtp_pkg::ST_MAX_RD;
                end
            end
            dtp_pkg::ST_EXP_RD:   state_next = dtp_pkg::ST_EXP_GO;
            dtp_pkg::ST_EXP_GO:   state_next = dtp_pkg::ST_EXP_WAIT;
            dtp_pkg::ST_EXP_WAIT:
            begin
                if (status.exp_done)
                begin
                    if (z_last_act)
                    begin
                        z_next     = '0;
                        state_next = dtp_pkg::ST_DIV_RD;
                    end
                    else
                    begin
                        z_next     = z_reg + TW'(1);
                        state_next = dtp_pkg::ST_EXP_RD;
                    end
                end
            end
            dtp_pkg::ST_DIV_RD:   state_next = dtp_pkg::ST_DIV_INIT;
            dtp_pkg::ST_DIV_INIT:
            begin
                step_next  = '0;
                state_next = dtp_pkg::ST_DIV_STEP;
            end
            dtp_pkg::ST_DIV_STEP:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(dtp_pkg::DIV_STEPS - 1))
                begin
                    state_next = dtp_pkg::ST_OUT;
                end
            end
            dtp_pkg::ST_OUT:
            begin
                if (!result_stall)
                begin
                    if (z_last_act)
                    begin
                        z_next     = '0;
                        state_next = dtp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        z_next     = z_reg + TW'(1);
                        state_next = dtp_pkg::ST_DIV_RD;
                    end
                end
            end
            default: state_next = dtp_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.last     = z_last_act;
        item_stall   = state_reg != dtp_pkg::ST_IDLE;
        result_valid = 1'b0;
        unique case (state_reg)
            dtp_pkg::ST_IDLE:
            begin
                cmd.load_word  = accept && kind == dtp_pkg::KIND_WORD;
                cmd.load_prior = accept && kind == dtp_pkg::KIND_PRIOR;
                cmd.feat_take  = accept && kind == dtp_pkg::KIND_FEAT;
            end
            dtp_pkg::ST_FEAT_RD:  cmd.rd = 1'b1;
            dtp_pkg::ST_FEAT_MUL:
            begin
                cmd.mul       = 1'b1;
                cmd.use_prior = !doc_open_reg;
            end
            dtp_pkg::ST_FEAT_WR:  cmd.score_we = 1'b1;
            dtp_pkg::ST_MAX_RD:   cmd.rd = 1'b1;
            dtp_pkg::ST_MAX_CMP:
            begin
                cmd.max_upd   = 1'b1;
                cmd.max_first = z_reg == '0;
            end
            dtp_pkg::ST_EXP_RD:
            begin
                cmd.rd      = 1'b1;
                cmd.sum_clr = z_reg == '0;
            end
            dtp_pkg::ST_EXP_GO:   cmd.exp_start = 1'b1;
            dtp_pkg::ST_EXP_WAIT: cmd.e_we = status.exp_done;
            dtp_pkg::ST_DIV_RD:   cmd.e_rd = 1'b1;
            dtp_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            dtp_pkg::ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                cmd.out_load = step_reg == 4'(dtp_pkg::DIV_STEPS - 1);
            end
            dtp_pkg::ST_OUT:      result_valid = 1'b1;
            default:              result_valid = 1'b0;
        endcase
    end

    assign topic_sel = z_reg;

endmodule

### hdl/dtp_checker.sv
// port level checks of the document topic posterior block, bound to the top level
// depends on dtp_pkg and document_topic_posterior_assert.svh
`timescale 1ns / 1ps
`include "document_topic_posterior_assert.svh"

module dtp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic [1:0]         kind,
    input logic               result_valid,
    input logic               result_stall,
    input logic [3:0]         topic_out,
    input logic [16:0]        posterior,
    input logic               last_topic
);

    `DTP_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(posterior) && $stable(topic_out) && $stable(last_topic), "stalled result changed")
    `DTP_ASSERT_IMP(a_busy, result_valid, item_stall, "item taken while a result is pending")
    `DTP_ASSERT_IMP(a_range, result_valid, posterior <= 17'd65536, "posterior above one")
    `DTP_ASSERT_NXT(a_load, item_valid && !item_stall && kind != dtp_pkg::KIND_FEAT, !result_valid, "result after a non-feature transfer")
    `DTP_ASSERT_NXT(a_last, result_valid && !result_stall && last_topic, !result_valid, "result after the last topic")

endmodule

bind document_topic_posterior dtp_checker u_dtp_checker (.*);
